// ----- design/ipe_pkg.sv -----
`timescale 1ns / 1ps
package ipe_pkg;

   localparam logic [7:0]  PROTO_IPIP     = 8'd4;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [7:0]  OUTER_TTL      = 8'd8;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] OUTER_HDR_LEN  = 16'd20;
   localparam logic [15:0] CSUM_BASE      = {IP_VER_IHL, 8'h00} + {OUTER_TTL, PROTO_IPIP};

   localparam int BURST_LEN  = 38;
   localparam int POS_W      = 6;
   localparam int QUEUE_AW   = 2;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST_MAC    = 2'd0,
      CSR_SRC_IP      = 2'd1,
      CSR_DST_IP      = 2'd2,
      CSR_ENTRY_VALID = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_end;
      logic       discard;
   } rsp_type;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic        entry_valid;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_PASS  = 2'd0,
      CMD_BURST = 2'd1,
      CMD_MARK  = 2'd2
   } cmd_kind_type;

   // one queued work item: a passed byte, a header burst or an empty drop marker
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         disc;
      logic [47:0]  old_dest_mac;
      logic [31:0]  ip_word0;
   } cmd_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_BURST = 1'b1
   } back_state_type;

endpackage

// ----- design/ipe_front.sv -----
`timescale 1ns / 1ps
module ipe_front
   import ipe_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 16383
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    entry_valid,
   input  logic    queue_full,
   output logic    push,
   output cmd_type push_cmd
);

   localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       proto_ff, proto_in;
   logic [47:0]      mac_ff, mac_in;
   logic [23:0]      ip_ff, ip_in;
   logic             accept;
   logic [7:0]       proto_eff;
   logic             disc;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign proto_eff = (idx_ff == IDX_W'(23)) ? req_data.frame_byte : proto_ff;

   always_comb begin
      disc = 1'b0;
      if (!entry_valid || idx_ff < IDX_W'(33)) begin
         disc = 1'b1;
      end else if (proto_eff == PROTO_TCP && idx_ff < IDX_W'(53)) begin
         disc = 1'b1;
      end else if (proto_eff == PROTO_UDP && idx_ff < IDX_W'(41)) begin
         disc = 1'b1;
      end
   end

   always_comb begin
      push                  = accept && (req_data.frame_end || idx_ff >= IDX_W'(17));
      push_cmd.data         = req_data.frame_byte;
      push_cmd.last         = req_data.frame_end;
      push_cmd.disc         = req_data.frame_end && disc;
      push_cmd.old_dest_mac = mac_ff;
      push_cmd.ip_word0     = {ip_ff, req_data.frame_byte};
      if (idx_ff < IDX_W'(17)) begin
         push_cmd.kind = CMD_MARK;
         push_cmd.disc = 1'b1;
      end else if (idx_ff == IDX_W'(17)) begin
         push_cmd.kind = CMD_BURST;
      end else begin
         push_cmd.kind = CMD_PASS;
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      proto_in = proto_ff;
      mac_in   = mac_ff;
      ip_in    = ip_ff;
      if (accept) begin
         // capture the old destination MAC and the first three IP header bytes
         if (idx_ff < IDX_W'(6)) begin
            mac_in[8*(5 - int'(idx_ff[2:0])) +: 8] = req_data.frame_byte;
         end
         if (idx_ff >= IDX_W'(14) && idx_ff < IDX_W'(17)) begin
            ip_in = {ip_ff[15:0], req_data.frame_byte};
         end
         if (req_data.frame_end) begin
            idx_in   = '0;
            proto_in = '0;
         end else begin
            if (idx_ff == IDX_W'(23)) begin
               proto_in = req_data.frame_byte;
            end
            if (idx_ff < IDX_W'(MAX_FRAME_BYTES)) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         proto_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         proto_ff <= proto_in;
      end
      mac_ff <= mac_in;
      ip_ff  <= ip_in;
   end

endmodule

// ----- design/ipe_queue.sv -----
`timescale 1ns / 1ps
module ipe_queue
   import ipe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int DEPTH = 2 ** QUEUE_AW;

   cmd_type             mem_ff [DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == (QUEUE_AW + 1)'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/ipe_back.sv -----
`timescale 1ns / 1ps
module ipe_back
   import ipe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   back_state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in, pos;
   logic [15:0]      tot_ff, tot_in, tot_new;
   logic [18:0]      acc_ff, acc_in;
   logic [15:0]      csum;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             slot_free, step, burst_done;
   logic [7:0]       burst_byte;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign step       = head_valid && slot_free;
   assign pos        = (state_ff == BK_IDLE) ? '0 : pos_ff;
   assign burst_done = pos == POS_W'(BURST_LEN - 1);
   assign tot_new    = head_cmd.ip_word0[15:0] + OUTER_HDR_LEN;
   assign csum       = ~(acc_ff[15:0] + {13'd0, acc_ff[18:16]});
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (step && head_cmd.kind == CMD_BURST) begin
               state_in = BK_BURST;
            end
         end
         BK_BURST: begin
            if (step && burst_done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      unique case (pos)
         6'd0:  burst_byte = cfg.dest_mac[47:40];
         6'd1:  burst_byte = cfg.dest_mac[39:32];
         6'd2:  burst_byte = cfg.dest_mac[31:24];
         6'd3:  burst_byte = cfg.dest_mac[23:16];
         6'd4:  burst_byte = cfg.dest_mac[15:8];
         6'd5:  burst_byte = cfg.dest_mac[7:0];
         6'd6:  burst_byte = head_cmd.old_dest_mac[47:40];
         6'd7:  burst_byte = head_cmd.old_dest_mac[39:32];
         6'd8:  burst_byte = head_cmd.old_dest_mac[31:24];
         6'd9:  burst_byte = head_cmd.old_dest_mac[23:16];
         6'd10: burst_byte = head_cmd.old_dest_mac[15:8];
         6'd11: burst_byte = head_cmd.old_dest_mac[7:0];
         6'd12: burst_byte = ETHERTYPE_IPV4[15:8];
         6'd13: burst_byte = ETHERTYPE_IPV4[7:0];
         6'd14: burst_byte = IP_VER_IHL;
         6'd16: burst_byte = tot_ff[15:8];
         6'd17: burst_byte = tot_ff[7:0];
         6'd22: burst_byte = OUTER_TTL;
         6'd23: burst_byte = PROTO_IPIP;
         6'd24: burst_byte = csum[15:8];
         6'd25: burst_byte = csum[7:0];
         6'd26: burst_byte = cfg.src_ip[31:24];
         6'd27: burst_byte = cfg.src_ip[23:16];
         6'd28: burst_byte = cfg.src_ip[15:8];
         6'd29: burst_byte = cfg.src_ip[7:0];
         6'd30: burst_byte = cfg.dst_ip[31:24];
         6'd31: burst_byte = cfg.dst_ip[23:16];
         6'd32: burst_byte = cfg.dst_ip[15:8];
         6'd33: burst_byte = cfg.dst_ip[7:0];
         6'd34: burst_byte = head_cmd.ip_word0[31:24];
         6'd35: burst_byte = head_cmd.ip_word0[23:16];
         6'd36: burst_byte = head_cmd.ip_word0[15:8];
         6'd37: burst_byte = head_cmd.ip_word0[7:0];
         default: burst_byte = 8'h00;
      endcase
   end

   // outputs
   always_comb begin
      pop          = 1'b0;
      pos_in       = pos_ff;
      tot_in       = tot_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step) begin
         rsp_valid_in = 1'b1;
         unique case (head_cmd.kind)
            CMD_PASS: begin
               pop    = 1'b1;
               rsp_in = '{out_byte: head_cmd.data, byte_present: 1'b1,
                          out_end: head_cmd.last, discard: head_cmd.disc};
            end
            CMD_MARK: begin
               pop    = 1'b1;
               rsp_in = '{out_byte: 8'h00, byte_present: 1'b0,
                          out_end: 1'b1, discard: 1'b1};
            end
            CMD_BURST: begin
               pop    = burst_done;
               pos_in = pos + 1'b1;
               rsp_in = '{out_byte: burst_byte, byte_present: 1'b1,
                          out_end: burst_done && head_cmd.last,
                          discard: burst_done && head_cmd.disc};
               // build the checksum sum one word per beat, done long before it goes out
               unique case (pos)
                  6'd0: begin
                     tot_in = tot_new;
                     acc_in = 19'(tot_new) + 19'(CSUM_BASE);
                  end
                  6'd1: acc_in = acc_ff + 19'(cfg.src_ip[31:16]);
                  6'd2: acc_in = acc_ff + 19'(cfg.src_ip[15:0]);
                  6'd3: acc_in = acc_ff + 19'(cfg.dst_ip[31:16]);
                  6'd4: acc_in = acc_ff + 19'(cfg.dst_ip[15:0]);
                  default: acc_in = acc_ff;
               endcase
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tot_ff <= tot_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- design/ipv4_in_ipv4_encapsulator.sv -----
`timescale 1ns / 1ps
// IPv4-in-IPv4 encapsulator.
// req_*: one Ethernet/IPv4 frame byte per beat, frame_end on the final byte.
// rsp_*: encapsulated frame bytes; out_end marks the last beat of a frame and
//   discard on that beat tells the receiver to drop the whole frame. A frame
//   that ends before its 18th byte gives one empty beat with byte_present low.
// csr_*: tunnel registers, to be written while no frame is in flight (unenforced).
// Bytes 0..16 produce nothing; byte 17 produces a 38-byte header burst (new
// Ethernet header, outer IPv4 header, first four inner IP bytes), and every
// later byte passes through as one beat. An accepted byte goes into the command
// queue, and its result beat is registered in the output stage. Pass-through
// runs at one byte per cycle while rsp_ready stays high; the header burst holds
// the output stage until its last beat, while the input keeps taking bytes until
// the 4-entry command queue fills; front and back stall independently there.
// Reset clears the frame position, the queue, the output stage and all
// tunnel registers. When the receiver holds rsp_ready low, the output beat
// holds, the queue fills, and then req_ready drops.
module ipv4_in_ipv4_encapsulator
   import ipe_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 16383
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    queue_full, push, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_MAC:    cfg_in.dest_mac    = csr_wdata;
            CSR_SRC_IP:      cfg_in.src_ip      = csr_wdata[31:0];
            CSR_DST_IP:      cfg_in.dst_ip      = csr_wdata[31:0];
            CSR_ENTRY_VALID: cfg_in.entry_valid = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipe_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .entry_valid(cfg_ff.entry_valid),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ipe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   ipe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/encap_checker.sv -----
`timescale 1ns / 1ps
module encap_checker
   import ipe_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 16383
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    beats_owed
);

   localparam int HDR_LEN       = 18;
   localparam int PROTO_POS     = 23;
   localparam int MIN_IP_FRAME  = 34;
   localparam int MIN_UDP_FRAME = 42;
   localparam int MIN_TCP_FRAME = 54;
   localparam int REPORT_LIMIT  = 10;

   logic [47:0] tun_dest_mac;
   logic [31:0] tun_src_ip;
   logic [31:0] tun_dst_ip;
   logic        tun_valid;

   int          byte_pos;
   logic [7:0]  hdr_bytes [HDR_LEN];
   logic [7:0]  inner_proto;
   rsp_type     expected_beats [$];
   rsp_type     want;

   task automatic encapsulate_byte(input req_type beat_in);
      logic [15:0] words [10];
      logic [31:0] acc;
      logic [15:0] total_len;
      logic [7:0]  burst [BURST_LEN];
      int          len;
      logic        drop;
      logic        last;

      if (byte_pos < HDR_LEN) hdr_bytes[byte_pos] = beat_in.frame_byte;
      if (byte_pos == PROTO_POS) inner_proto = beat_in.frame_byte;
      len  = byte_pos + 1;
      drop = beat_in.frame_end &&
             (!tun_valid || len < MIN_IP_FRAME ||
              (inner_proto == PROTO_TCP && len < MIN_TCP_FRAME) ||
              (inner_proto == PROTO_UDP && len < MIN_UDP_FRAME));

      if (byte_pos < HDR_LEN - 1) begin
         if (beat_in.frame_end)
            expected_beats.push_back(rsp_type'{8'h00, 1'b0, 1'b1, 1'b1});
      end else if (byte_pos == HDR_LEN - 1) begin
         total_len = {hdr_bytes[16], hdr_bytes[17]} + OUTER_HDR_LEN;
         words[0] = {IP_VER_IHL, 8'h00};
         words[1] = total_len;
         words[2] = 16'h0000;
         words[3] = 16'h0000;
         words[4] = {OUTER_TTL, PROTO_IPIP};
         words[5] = 16'h0000;
         words[6] = tun_src_ip[31:16];
         words[7] = tun_src_ip[15:0];
         words[8] = tun_dst_ip[31:16];
         words[9] = tun_dst_ip[15:0];
         acc = '0;
         for (int i = 0; i < 10; i++) acc += 32'(words[i]);
         // fold once only; a carry out of the fold is lost
         words[5] = ~(acc[15:0] + acc[31:16]);

         for (int i = 0; i < 6; i++) begin
            burst[i]     = tun_dest_mac[47 - 8 * i -: 8];
            burst[6 + i] = hdr_bytes[i];
         end
         burst[12] = ETHERTYPE_IPV4[15:8];
         burst[13] = ETHERTYPE_IPV4[7:0];
         for (int i = 0; i < 10; i++) begin
            burst[14 + 2 * i] = words[i][15:8];
            burst[15 + 2 * i] = words[i][7:0];
         end
         for (int i = 0; i < 4; i++) burst[34 + i] = hdr_bytes[14 + i];

         for (int i = 0; i < BURST_LEN; i++) begin
            last = (i == BURST_LEN - 1) && beat_in.frame_end;
            expected_beats.push_back(rsp_type'{burst[i], 1'b1, last, last && drop});
         end
      end else begin
         expected_beats.push_back(rsp_type'{beat_in.frame_byte, 1'b1,
                                            beat_in.frame_end, drop});
      end

      if (beat_in.frame_end) begin
         byte_pos    = 0;
         inner_proto = 8'h00;
      end else if (byte_pos < MAX_FRAME_BYTES) begin
         byte_pos++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tun_dest_mac = '0;
         tun_src_ip   = '0;
         tun_dst_ip   = '0;
         tun_valid    = 1'b0;
         byte_pos     = 0;
         inner_proto  = 8'h00;
         error_count  = 0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DEST_MAC:    tun_dest_mac = csr_wdata[47:0];
               CSR_SRC_IP:      tun_src_ip   = csr_wdata[31:0];
               CSR_DST_IP:      tun_dst_ip   = csr_wdata[31:0];
               CSR_ENTRY_VALID: tun_valid    = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) encapsulate_byte(req_data);

         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: unexpected beat byte %h present %b end %b discard %b",
                           $realtime, rsp_data.out_byte, rsp_data.byte_present,
                           rsp_data.out_end, rsp_data.discard);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_present !== want.byte_present ||
                   rsp_data.out_end !== want.out_end ||
                   rsp_data.discard !== want.discard) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: beat mismatch, expected %h/%b/%b/%b got %h/%b/%b/%b",
                              $realtime, want.out_byte, want.byte_present, want.out_end,
                              want.discard, rsp_data.out_byte, rsp_data.byte_present,
                              rsp_data.out_end, rsp_data.discard);
               end
            end
         end
      end
      beats_owed = expected_beats.size();
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import ipe_pkg::*;

   localparam int ETH_TYPE_POS     = 12;
   localparam int IP_LEN_POS       = 16;
   localparam int IP_PROTO_POS     = 23;
   localparam int NO_OVERRIDE      = -1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    error_count;
   int                    beats_owed;
   bit                    steady    = 1'b0;

   always #10 clock = ~clock;

   ipv4_in_ipv4_encapsulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   encap_checker encap_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .beats_owed  (beats_owed)
   );

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 34);
   end

   // entered and left at a falling edge; valid stays up for a following beat
   task automatic push_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.frame_byte <= b;
      req_data.frame_end  <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // proto >= 0 shapes an IPv4 frame; ip_len >= 0 sets the inner total length
   task automatic send_frame(input int len, input int proto, input int ip_len,
                             input int fill);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         if (proto >= 0) begin
            if (i == ETH_TYPE_POS)     b = ETHERTYPE_IPV4[15:8];
            if (i == ETH_TYPE_POS + 1) b = ETHERTYPE_IPV4[7:0];
            if (i == IP_PROTO_POS)     b = 8'(proto);
         end
         if (ip_len >= 0) begin
            if (i == IP_LEN_POS)     b = ip_len[15:8];
            if (i == IP_LEN_POS + 1) b = ip_len[7:0];
         end
         push_byte(b, i == len - 1);
      end
   endtask

   task automatic program_tunnel(input logic [47:0] mac, input logic [31:0] sip,
                                 input logic [31:0] dip, input logic entry_ok);
      req_valid <= 1'b0;
      while (beats_owed != 0) @(negedge clock);
      // let the pipeline drain behind the last beat
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEST_MAC;
      csr_wdata <= mac;
      @(negedge clock);
      csr_index <= CSR_SRC_IP;
      csr_wdata <= CSR_DATA_W'(sip);
      @(negedge clock);
      csr_index <= CSR_DST_IP;
      csr_wdata <= CSR_DATA_W'(dip);
      @(negedge clock);
      csr_index <= CSR_ENTRY_VALID;
      csr_wdata <= CSR_DATA_W'(entry_ok);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int quota);
      int sent;
      int len;
      int pick;
      int proto;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            len = $urandom_range(34, 72);
            case ($urandom_range(0, 2))
               0: proto = PROTO_TCP;
               1: proto = PROTO_UDP;
               default: proto = $urandom_range(0, 255);
            endcase
            send_frame(len, proto, $urandom_range(0, 65535), NO_OVERRIDE);
         end else if (pick < 80) begin
            len = $urandom_range(1, 33);
            send_frame(len, NO_OVERRIDE, NO_OVERRIDE, NO_OVERRIDE);
         end else begin
            len = $urandom_range(1, 60);
            send_frame(len, NO_OVERRIDE, NO_OVERRIDE, NO_OVERRIDE);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      program_tunnel('1, '1, '1, 1'b1);
      send_frame(1, NO_OVERRIDE, NO_OVERRIDE, 8'hff);
      send_frame(17, NO_OVERRIDE, NO_OVERRIDE, 8'h00);
      // outer total length wraps past 16 bits, frame ends on the burst
      send_frame(18, NO_OVERRIDE, 16'hfff0, 8'hff);
      // all-ones addresses with this length push the checksum fold past 16 bits
      send_frame(40, 1, 16'hb2ea, NO_OVERRIDE);

      // stream both sides with no idle cycles around the length limits
      steady <= 1'b1;
      send_frame(53, PROTO_TCP, 39, NO_OVERRIDE);
      send_frame(42, PROTO_UDP, 28, NO_OVERRIDE);
      steady <= 1'b0;

      program_tunnel('0, '0, '0, 1'b0);
      random_phase(20);

      program_tunnel(48'({$urandom, $urandom}), $urandom, $urandom, 1'b1);
      random_phase(20);

      req_valid <= 1'b0;
      while (beats_owed != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && beats_owed == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
